FILE: rtl/core/pic_pkg.sv
package pic_pkg;

  localparam int unsigned MAX_ANIMALS_DEF = 4096;
  localparam int unsigned CNT_W           = 13;
  localparam int unsigned OUT_IDX_W       = 12;
  localparam int unsigned VAL_W           = 32;

  localparam logic signed [VAL_W-1:0] ONE_Q28     = 32'sh1000_0000;
  localparam logic signed [VAL_W-1:0] HALF_Q28    = 32'sh0800_0000;
  localparam logic signed [VAL_W-1:0] UNK_F_RESET = 32'shF000_0000;
  localparam logic [CNT_W-1:0]        COUNT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    CFG_RECOMPUTE    = 2'd0,
    CFG_ANIMAL_COUNT = 2'd1,
    CFG_UNKNOWN_F    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                    start_of_pedigree;
    logic [CNT_W-1:0]        dam_index;
    logic [CNT_W-1:0]        sire_index;
    logic signed [VAL_W-1:0] given_f;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]    animal_index;
    logic signed [VAL_W-1:0] dii_value;
    logic signed [VAL_W-1:0] inbreeding_f;
    logic                    order_error;
    logic                    saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_RD_FD, OP_RD_FS, OP_RD_PREV, OP_DII,
    OP_V_SRD, OP_V_SWR, OP_V_DRD, OP_V_DWR, OP_SCAN_RD, OP_SCAN_CHK, OP_FIN, OP_DONE
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_FD, ST_RD_FS, ST_RD_PREV, ST_DII,
    ST_V_SRD, ST_V_SWR, ST_V_DRD, ST_V_DWR, ST_SCAN_RD, ST_SCAN_CHK, ST_FIN, ST_DONE
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic recompute;
    logic same_par;
    logic j_zero;
    logic weight_zero;
    logic out_free;
  } status_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [39:0] x);
    if (x > 40'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

  function automatic logic ovf32(input logic signed [39:0] x);
    return (x > 40'sd2147483647) || (x < -40'sd2147483648);
  endfunction

endpackage

FILE: rtl/core/pic_stream_if.sv
interface pic_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/pic_ram.sv
module pic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/pic_ctrl.sv
module pic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pic_pkg::status_t  status_i,
  output pic_pkg::cmd_t     cmd_o
);
  import pic_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.op = OP_CLEAR;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = ST_RD_FD;
        end
      end
      ST_RD_FD: begin
        cmd_o.op = OP_RD_FD;
        state_d  = ST_RD_FS;
      end
      ST_RD_FS: begin
        cmd_o.op = OP_RD_FS;
        state_d  = ST_RD_PREV;
      end
      ST_RD_PREV: begin
        cmd_o.op = OP_RD_PREV;
        state_d  = ST_DII;
      end
      ST_DII: begin
        cmd_o.op = OP_DII;
        state_d  = (!status_i.recompute || status_i.same_par) ? ST_DONE : ST_V_SRD;
      end
      ST_V_SRD: begin
        cmd_o.op = OP_V_SRD;
        state_d  = ST_V_SWR;
      end
      ST_V_SWR: begin
        cmd_o.op = OP_V_SWR;
        state_d  = ST_V_DRD;
      end
      ST_V_DRD: begin
        cmd_o.op = OP_V_DRD;
        state_d  = ST_V_DWR;
      end
      ST_V_DWR: begin
        cmd_o.op = OP_V_DWR;
        state_d  = status_i.j_zero ? ST_FIN : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        cmd_o.op = OP_SCAN_CHK;
        if (!status_i.weight_zero) begin
          state_d = ST_V_SRD;
        end else begin
          state_d = status_i.j_zero ? ST_FIN : ST_SCAN_RD;
        end
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.op = OP_DONE;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule

FILE: rtl/core/pic_dpath.sv
module pic_dpath #(
  parameter int unsigned MAX_ANIMALS = pic_pkg::MAX_ANIMALS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  pic_pkg::in_item_t  in_data_i,
  input  pic_pkg::cmd_t      cmd_i,
  output pic_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pic_pkg::out_item_t out_data_o
);
  import pic_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ANIMALS);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned CW = (NW > CNT_W) ? NW : CNT_W;
  localparam int unsigned PW = 2 * IW + 2;

  logic                    recompute_q;
  logic [CNT_W-1:0]        count_q;
  logic signed [VAL_W-1:0] unk_q;
  logic [NW-1:0]           clr_q, next_q;
  logic [CNT_W-1:0]        prev_dam_q, prev_sire_q, dam_q, sire_q;
  logic [IW-1:0]           k_q, j_q, pd_q, ps_q;
  logic                    dk_q, sk_q, err_q, sat_q, pdok_q, psok_q, out_valid_q;
  logic signed [VAL_W-1:0] given_q, fd_q, fs_q, dii_q, f_q, ai_q, l_q, l2_q, var_q;
  logic signed [63:0]      mul1_q, mul2_q;
  out_item_t               out_q;

  logic [IW-1:0]           k_new;
  logic                    dk_new, sk_new, derr, serr, out_free, same_par;
  logic signed [33:0]      fsum;
  logic signed [39:0]      dii_x, same_x, lnew_x, l2_x, ai_x, fin_x;
  logic signed [VAL_W-1:0] c_rd, l_rd, var_rd;
  logic [PW-1:0]           par_rd;

  logic                    c_we, l_we;
  logic [IW-1:0]           c_raddr, l_waddr, l_raddr;
  logic signed [VAL_W-1:0] l_wdata;

  assign k_new  = (in_data_i.start_of_pedigree || next_q >= NW'(MAX_ANIMALS)) ? '0 : next_q[IW-1:0];
  assign derr   = (in_data_i.dam_index != count_q) && (CW'(in_data_i.dam_index) >= CW'(k_new));
  assign serr   = (in_data_i.sire_index != count_q) && (CW'(in_data_i.sire_index) >= CW'(k_new));
  assign dk_new = (in_data_i.dam_index != count_q) && !derr;
  assign sk_new = (in_data_i.sire_index != count_q) && !serr;

  assign same_par = (k_q != '0) && (dam_q == prev_dam_q) && (sire_q == prev_sire_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign fsum   = 34'(fd_q) + 34'(fs_q);
  assign dii_x  = 40'(HALF_Q28) - 40'(fsum >>> 2);
  assign same_x = 40'(given_q) + 40'(c_rd);
  assign lnew_x = 40'(l_rd) + 40'(l_q >>> 1);
  assign l2_x   = 40'(mul1_q >>> 28);
  assign ai_x   = 40'(ai_q) + 40'(mul2_q >>> 28);
  assign fin_x  = 40'(ai_q) - 40'(ONE_Q28);

  always_comb begin
    c_raddr = IW'(k_q - 1'b1);
    case (cmd_i.op)
      OP_RD_FD: c_raddr = IW'(dam_q);
      OP_RD_FS: c_raddr = IW'(sire_q);
      default:  c_raddr = IW'(k_q - 1'b1);
    endcase
  end
  assign c_we = (cmd_i.op == OP_DONE) && out_free;

  always_comb begin
    l_we    = 1'b0;
    l_waddr = j_q;
    l_wdata = sat32(lnew_x);
    l_raddr = j_q;
    case (cmd_i.op)
      OP_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr_q[IW-1:0];
        l_wdata = '0;
      end
      OP_V_SRD: begin
        l_we    = 1'b1;
        l_wdata = '0;
        l_raddr = ps_q;
      end
      OP_V_SWR: begin
        l_we    = psok_q;
        l_waddr = ps_q;
      end
      OP_V_DRD: l_raddr = pd_q;
      OP_V_DWR: begin
        l_we    = pdok_q;
        l_waddr = pd_q;
      end
      default: ;
    endcase
  end

  pic_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ANIMALS)) u_coeff (
    .clk_i, .we_i(c_we), .waddr_i(k_q), .wdata_i(f_q), .raddr_i(c_raddr), .rdata_o(c_rd)
  );
  pic_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ANIMALS)) u_var (
    .clk_i, .we_i(cmd_i.op == OP_DII), .waddr_i(k_q), .wdata_i(sat32(dii_x)),
    .raddr_i(j_q), .rdata_o(var_rd)
  );
  pic_ram #(.WIDTH(PW), .DEPTH(MAX_ANIMALS)) u_par (
    .clk_i, .we_i(cmd_i.op == OP_DII), .waddr_i(k_q),
    .wdata_i({dk_q, sk_q, IW'(dam_q), IW'(sire_q)}), .raddr_i(j_q), .rdata_o(par_rd)
  );
  pic_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ANIMALS)) u_weight (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata), .raddr_i(l_raddr),
    .rdata_o(l_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recompute_q <= 1'b1;
      count_q     <= COUNT_RESET;
      unk_q       <= UNK_F_RESET;
      clr_q       <= '0;
      next_q      <= '0;
      prev_dam_q  <= '0;
      prev_sire_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RECOMPUTE:    recompute_q <= cfg_wdata_i[0];
          CFG_ANIMAL_COUNT: count_q     <= cfg_wdata_i[CNT_W-1:0];
          CFG_UNKNOWN_F:    unk_q       <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (c_we) begin
        out_valid_q <= 1'b1;
        next_q      <= NW'(k_q) + 1'b1;
        prev_dam_q  <= dam_q;
        prev_sire_q <= sire_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        k_q     <= k_new;
        dam_q   <= in_data_i.dam_index;
        sire_q  <= in_data_i.sire_index;
        given_q <= in_data_i.given_f;
        dk_q    <= dk_new;
        sk_q    <= sk_new;
        err_q   <= derr || serr;
        sat_q   <= 1'b0;
      end
      OP_RD_FS:   fd_q <= dk_q ? c_rd : unk_q;
      OP_RD_PREV: fs_q <= sk_q ? c_rd : unk_q;
      OP_DII: begin
        dii_q  <= sat32(dii_x);
        var_q  <= sat32(dii_x);
        sat_q  <= sat_q | ovf32(dii_x) | (recompute_q && same_par && ovf32(same_x));
        f_q    <= !recompute_q ? given_q : sat32(same_x);
        l_q    <= ONE_Q28;
        ps_q   <= IW'(sire_q);
        pd_q   <= IW'(dam_q);
        psok_q <= sk_q;
        pdok_q <= dk_q;
        j_q    <= k_q;
        ai_q   <= '0;
      end
      OP_V_SRD: mul1_q <= l_q * l_q;
      OP_V_SWR: begin
        l2_q  <= sat32(l2_x);
        sat_q <= sat_q | ovf32(l2_x) | (psok_q && ovf32(lnew_x));
      end
      OP_V_DRD: mul2_q <= l2_q * var_q;
      OP_V_DWR: begin
        ai_q  <= sat32(ai_x);
        sat_q <= sat_q | ovf32(ai_x) | (pdok_q && ovf32(lnew_x));
        if (j_q != '0) begin
          j_q <= j_q - 1'b1;
        end
      end
      OP_SCAN_CHK: begin
        if (l_rd != '0) begin
          l_q                          <= l_rd;
          {pdok_q, psok_q, pd_q, ps_q} <= par_rd;
          var_q                        <= var_rd;
        end else if (j_q != '0) begin
          j_q <= j_q - 1'b1;
        end
      end
      OP_FIN: begin
        f_q   <= sat32(fin_x);
        sat_q <= sat_q | ovf32(fin_x);
      end
      OP_DONE: begin
        if (out_free) begin
          out_q.animal_index <= OUT_IDX_W'(k_q);
          out_q.dii_value    <= dii_q;
          out_q.inbreeding_f <= f_q;
          out_q.order_error  <= err_q;
          out_q.saturated    <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign status_o.clr_done    = (clr_q == NW'(MAX_ANIMALS));
  assign status_o.recompute   = recompute_q;
  assign status_o.same_par    = same_par;
  assign status_o.j_zero      = (j_q == '0);
  assign status_o.weight_zero = (l_rd == '0);
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

FILE: rtl/core/pedigree_inbreeding_coefficients_core.sv
// When F is given (recompute off) or the item repeats the previous sibling's parents, no scan is run.
// Otherwise the path weight RAM is scanned down from animal index k, with a read state
// and a check state per index for the registered RAM read, and each earlier ancestor
// with a nonzero weight is visited through the sire and dam read/write states. One item
// in flight; the next is taken while a finished result waits at the output.
// Reset (async, active low) clears control state, then a sweep over all MAX_ANIMALS
// entries zeroes the path weight RAM before the first item is taken.
module pedigree_inbreeding_coefficients_core #(
  parameter int unsigned MAX_ANIMALS = pic_pkg::MAX_ANIMALS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  pic_stream_if.sink   in_if,
  pic_stream_if.source out_if
);
  import pic_pkg::*;

  cmd_t      cmd;
  status_t   status;
  in_item_t  in_data;
  out_item_t out_data;

  assign in_data     = in_if.data;
  assign out_if.data = out_data;

  pic_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .status_i(status), .cmd_o(cmd)
  );

  pic_dpath #(.MAX_ANIMALS(MAX_ANIMALS)) u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_data_i(in_data), .cmd_i(cmd), .status_o(status),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_data)
  );
endmodule

FILE: rtl/core/pic_checker.sv
module pic_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in flight");
endmodule

bind pedigree_inbreeding_coefficients_core pic_checker u_pic_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready)
);
